/* hdl/crf_pkg.sv */
// Shared types and constants for the clipped raster fill engine.
`default_nettype none

package crf_pkg;

    // Command codes carried in the cmd field of an input word
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_POINT  = 3'd1;
    localparam logic [2:0] CMD_FILL   = 3'd2;
    localparam logic [2:0] CMD_BORDER = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    // Register indexes, one register per 8-byte slot
    localparam logic [2:0] REG_PALETTE     = 3'd0;
    localparam logic [2:0] REG_CLIP_LEFT   = 3'd1;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
    localparam logic [2:0] REG_CLIP_RIGHT  = 3'd3;
    localparam logic [2:0] REG_CLIP_BOTTOM = 3'd4;

    // Command word
    typedef struct packed {
        logic        [2:0]  cmd;
        logic signed [15:0] xa;
        logic signed [15:0] ya;
        logic signed [15:0] xb;
        logic signed [15:0] yb;
        logic        [3:0]  color;
    } in_word_t;

    // Completion word
    typedef struct packed {
        logic [3:0] pixel_value;
        logic       off_canvas;
    } out_word_t;

    // Register file contents as seen by the engine
    typedef struct packed {
        logic [63:0] palette_map;
        logic [7:0]  clip_left;
        logic [7:0]  clip_top;
        logic [7:0]  clip_right;
        logic [7:0]  clip_bottom;
    } cfg_t;

    // Engine sequencer states
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SETUP,
        ST_PLAN,
        ST_NEXT,
        ST_SPAN,
        ST_CLEAR,
        ST_READ,
        ST_RWAIT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* hdl/crf_regs.sv */
// APB register file: palette map and clip window.
`default_nettype none

module crf_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [5:0]    paddr,
    input  wire logic [63:0]   pwdata,
    output logic      [63:0]   prdata,
    output logic               pready,
    output crf_pkg::cfg_t      cfg
);

    localparam logic [63:0] PALETTE_RESET = 64'hFEDC_BA98_7654_3210;

    logic [63:0] palette_reg;
    logic [7:0]  left_reg;
    logic [7:0]  top_reg;
    logic [7:0]  right_reg;
    logic [7:0]  bottom_reg;
    logic [2:0]  index;
    logic        wr_en;

    assign pready = 1'b1;
    assign index  = paddr[5:3];
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_reg <= PALETTE_RESET;
            left_reg    <= 8'd0;
            top_reg     <= 8'd0;
            right_reg   <= 8'd255;
            bottom_reg  <= 8'd255;
        end else if (wr_en) begin
            case (index)
                crf_pkg::REG_PALETTE:     palette_reg <= pwdata;
                crf_pkg::REG_CLIP_LEFT:   left_reg    <= pwdata[7:0];
                crf_pkg::REG_CLIP_TOP:    top_reg     <= pwdata[7:0];
                crf_pkg::REG_CLIP_RIGHT:  right_reg   <= pwdata[7:0];
                crf_pkg::REG_CLIP_BOTTOM: bottom_reg  <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (index)
            crf_pkg::REG_PALETTE:     prdata = palette_reg;
            crf_pkg::REG_CLIP_LEFT:   prdata = {56'd0, left_reg};
            crf_pkg::REG_CLIP_TOP:    prdata = {56'd0, top_reg};
            crf_pkg::REG_CLIP_RIGHT:  prdata = {56'd0, right_reg};
            crf_pkg::REG_CLIP_BOTTOM: prdata = {56'd0, bottom_reg};
            default:                  prdata = 64'd0;
        endcase
    end

    assign cfg.palette_map = palette_reg;
    assign cfg.clip_left   = left_reg;
    assign cfg.clip_top    = top_reg;
    assign cfg.clip_right  = right_reg;
    assign cfg.clip_bottom = bottom_reg;

endmodule

`default_nettype wire

/* hdl/crf_fstore.sv */
// Frame store: one write port and one registered read port.
`default_nettype none

module crf_fstore #(
    parameter int DEPTH = 65536
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [3:0]                                wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [3:0]                                rdata
);

    logic [3:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/crf_engine.sv */
// Command sequencer: clip math, span walker, clear sweep and result register.
`default_nettype none

module crf_engine #(
    parameter int CANVAS_WIDTH  = 256,
    parameter int CANVAS_HEIGHT = 256,
    parameter int PALETTE_SIZE  = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire crf_pkg::cfg_t     cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire crf_pkg::in_word_t s_word,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output crf_pkg::out_word_t     m_word,
    output logic                   mem_we,
    output logic [((CANVAS_WIDTH * CANVAS_HEIGHT > 1) ?
                   $clog2(CANVAS_WIDTH * CANVAS_HEIGHT) : 1)-1:0] mem_waddr,
    output logic [3:0]             mem_wdata,
    output logic                   mem_re,
    output logic [((CANVAS_WIDTH * CANVAS_HEIGHT > 1) ?
                   $clog2(CANVAS_WIDTH * CANVAS_HEIGHT) : 1)-1:0] mem_raddr,
    input  wire logic [3:0]        mem_rdata
);

    localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (CANVAS_WIDTH > 1) ? $clog2(CANVAS_WIDTH) : 1;
    localparam int YW    = (CANVAS_HEIGHT > 1) ? $clog2(CANVAS_HEIGHT) : 1;

    localparam logic [AW-1:0]        ROW_STRIDE = AW'(CANVAS_WIDTH);
    localparam logic [AW-1:0]        LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic signed [17:0]   X_MAX      = 18'(CANVAS_WIDTH - 1);
    localparam logic signed [17:0]   Y_MAX      = 18'(CANVAS_HEIGHT - 1);
    localparam logic [3:0]           COLOR_TOP  = 4'(PALETTE_SIZE - 1);

    crf_pkg::state_t   state_reg, state_next;
    crf_pkg::in_word_t item_reg;
    crf_pkg::out_word_t out_word_reg;
    logic              out_valid_reg;

    // Clipped rectangle and edge qualifiers
    logic signed [17:0] l_reg, r_reg, t_reg, b_reg;
    logic               xa_in_reg, xb_in_reg, ya_in_reg, yb_in_reg;
    logic [3:0]         color_reg;
    logic [3:0]         pix_reg;
    logic               off_reg;

    // Span walker
    logic [3:0]    span_en_reg;
    logic [XW-1:0] x_reg, x0_reg, x1_reg;
    logic [YW-1:0] y_reg, y1_reg;
    logic [AW-1:0] clr_addr_reg;

    // Setup-stage combinational values
    logic signed [17:0] xa18, ya18, xb18, yb18;
    logic signed [17:0] cl18, ct18, er18, eb18, cr18, cbt18;
    logic signed [17:0] minx, maxx, miny, maxy;
    logic signed [17:0] l_s, r_s, t_s, b_s;
    logic [3:0]         color_idx;
    logic               off_s;

    logic       rect_x_ok, rect_y_ok;
    logic [3:0] en_plan;

    logic [1:0]    pick;
    logic [XW-1:0] ld_x0, ld_x1;
    logic [YW-1:0] ld_y0, ld_y1;
    logic [XW-1:0] xa_c, xb_c, l_c, r_c;
    logic [YW-1:0] ya_c, yb_c, t_c, b_c;

    logic          x_end, y_end;
    logic          accept, done_load;
    logic [XW-1:0] addr_x;
    logic [YW-1:0] addr_y;
    logic [AW-1:0] pix_addr;

    assign accept    = s_valid && s_ready;
    assign done_load = (state_reg == crf_pkg::ST_DONE) && (!out_valid_reg || m_ready);

    // Widen operands for signed compares
    assign xa18  = {{2{item_reg.xa[15]}}, item_reg.xa};
    assign ya18  = {{2{item_reg.ya[15]}}, item_reg.ya};
    assign xb18  = {{2{item_reg.xb[15]}}, item_reg.xb};
    assign yb18  = {{2{item_reg.yb[15]}}, item_reg.yb};
    assign cl18  = $signed({10'd0, cfg.clip_left});
    assign ct18  = $signed({10'd0, cfg.clip_top});
    assign cr18  = $signed({10'd0, cfg.clip_right});
    assign cbt18 = $signed({10'd0, cfg.clip_bottom});

    // Effective clip limits never pass the canvas edge
    assign er18 = (cr18 > X_MAX) ? X_MAX : cr18;
    assign eb18 = (cbt18 > Y_MAX) ? Y_MAX : cbt18;

    // Normalize corners, then clip
    assign minx = (xa18 < xb18) ? xa18 : xb18;
    assign maxx = (xa18 > xb18) ? xa18 : xb18;
    assign miny = (ya18 < yb18) ? ya18 : yb18;
    assign maxy = (ya18 > yb18) ? ya18 : yb18;
    assign l_s  = (minx > cl18) ? minx : cl18;
    assign r_s  = (maxx < er18) ? maxx : er18;
    assign t_s  = (miny > ct18) ? miny : ct18;
    assign b_s  = (maxy < eb18) ? maxy : eb18;

    assign off_s = (xa18 < 0) || (ya18 < 0) || (xa18 > X_MAX) || (ya18 > Y_MAX);

    // Colors past the palette size saturate
    assign color_idx = (item_reg.color > COLOR_TOP) ? COLOR_TOP : item_reg.color;

    // Which spans a command draws
    assign rect_x_ok = (l_reg <= r_reg);
    assign rect_y_ok = (t_reg <= b_reg);

    always_comb begin
        case (item_reg.cmd)
            crf_pkg::CMD_POINT:  en_plan = {3'b000, xa_in_reg && ya_in_reg};
            crf_pkg::CMD_FILL:   en_plan = {3'b000, rect_x_ok && rect_y_ok};
            crf_pkg::CMD_BORDER: en_plan = {yb_in_reg && rect_x_ok, ya_in_reg && rect_x_ok,
                                            xb_in_reg && rect_y_ok, xa_in_reg && rect_y_ok};
            default:             en_plan = 4'b0000;
        endcase
    end

    // Coordinates are in range whenever the span using them is enabled
    assign xa_c = item_reg.xa[XW-1:0];
    assign xb_c = item_reg.xb[XW-1:0];
    assign ya_c = item_reg.ya[YW-1:0];
    assign yb_c = item_reg.yb[YW-1:0];
    assign l_c  = l_reg[XW-1:0];
    assign r_c  = r_reg[XW-1:0];
    assign t_c  = t_reg[YW-1:0];
    assign b_c  = b_reg[YW-1:0];

    // Lowest pending span first
    always_comb begin
        if (span_en_reg[0]) begin
            pick = 2'd0;
        end else if (span_en_reg[1]) begin
            pick = 2'd1;
        end else if (span_en_reg[2]) begin
            pick = 2'd2;
        end else begin
            pick = 2'd3;
        end
    end

    // Span bounds for the picked entry
    always_comb begin
        ld_x0 = l_c;
        ld_x1 = r_c;
        ld_y0 = t_c;
        ld_y1 = b_c;
        case (item_reg.cmd)
            crf_pkg::CMD_POINT: begin
                ld_x0 = xa_c;
                ld_x1 = xa_c;
                ld_y0 = ya_c;
                ld_y1 = ya_c;
            end
            crf_pkg::CMD_BORDER: begin
                case (pick)
                    2'd0: begin
                        ld_x0 = xa_c;
                        ld_x1 = xa_c;
                    end
                    2'd1: begin
                        ld_x0 = xb_c;
                        ld_x1 = xb_c;
                    end
                    2'd2: begin
                        ld_y0 = ya_c;
                        ld_y1 = ya_c;
                    end
                    default: begin
                        ld_y0 = yb_c;
                        ld_y1 = yb_c;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign x_end = (x_reg == x1_reg);
    assign y_end = (y_reg == y1_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crf_pkg::ST_INIT: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = crf_pkg::ST_IDLE;
                end
            end
            crf_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = crf_pkg::ST_SETUP;
                end
            end
            crf_pkg::ST_SETUP: begin
                case (item_reg.cmd)
                    crf_pkg::CMD_CLEAR:  state_next = crf_pkg::ST_CLEAR;
                    crf_pkg::CMD_POINT,
                    crf_pkg::CMD_FILL,
                    crf_pkg::CMD_BORDER: state_next = crf_pkg::ST_PLAN;
                    crf_pkg::CMD_READ:   state_next = off_s ? crf_pkg::ST_DONE
                                                            : crf_pkg::ST_READ;
                    default:             state_next = crf_pkg::ST_DONE;
                endcase
            end
            crf_pkg::ST_PLAN:  state_next = crf_pkg::ST_NEXT;
            crf_pkg::ST_NEXT: begin
                state_next = (span_en_reg == 4'b0000) ? crf_pkg::ST_DONE : crf_pkg::ST_SPAN;
            end
            crf_pkg::ST_SPAN: begin
                if (x_end && y_end) begin
                    state_next = crf_pkg::ST_NEXT;
                end
            end
            crf_pkg::ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = crf_pkg::ST_DONE;
                end
            end
            crf_pkg::ST_READ:  state_next = crf_pkg::ST_RWAIT;
            crf_pkg::ST_RWAIT: state_next = crf_pkg::ST_DONE;
            crf_pkg::ST_DONE: begin
                if (done_load) begin
                    state_next = crf_pkg::ST_IDLE;
                end
            end
            default: state_next = crf_pkg::ST_IDLE;
        endcase
    end

    // Pixel address: read position or walker position
    assign addr_x   = (state_reg == crf_pkg::ST_READ) ? xa_c : x_reg;
    assign addr_y   = (state_reg == crf_pkg::ST_READ) ? ya_c : y_reg;
    assign pix_addr = AW'(addr_y) * ROW_STRIDE + AW'(addr_x);

    // Outputs
    always_comb begin
        s_ready   = (state_reg == crf_pkg::ST_IDLE);
        mem_we    = 1'b0;
        mem_waddr = pix_addr;
        mem_wdata = color_reg;
        mem_re    = 1'b0;
        mem_raddr = pix_addr;
        case (state_reg)
            crf_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 4'd0;
            end
            crf_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
            end
            crf_pkg::ST_SPAN: mem_we = 1'b1;
            crf_pkg::ST_READ: mem_re = 1'b1;
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= crf_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
            clr_addr_reg  <= '0;
            span_en_reg   <= 4'b0000;
        end else begin
            state_reg <= state_next;

            if (done_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            // Sweep counter shared by reset clear and clear command
            if (state_reg == crf_pkg::ST_INIT || state_reg == crf_pkg::ST_CLEAR) begin
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + AW'(1);
            end

            if (state_reg == crf_pkg::ST_PLAN) begin
                span_en_reg <= en_plan;
            end else if (state_reg == crf_pkg::ST_NEXT && span_en_reg != 4'b0000) begin
                span_en_reg[pick] <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_word;
        end

        if (state_reg == crf_pkg::ST_SETUP) begin
            l_reg     <= l_s;
            r_reg     <= r_s;
            t_reg     <= t_s;
            b_reg     <= b_s;
            xa_in_reg <= (xa18 >= cl18) && (xa18 <= er18);
            xb_in_reg <= (xb18 >= cl18) && (xb18 <= er18);
            ya_in_reg <= (ya18 >= ct18) && (ya18 <= eb18);
            yb_in_reg <= (yb18 >= ct18) && (yb18 <= eb18);
            color_reg <= cfg.palette_map[{color_idx, 2'b00} +: 4];
            off_reg   <= (item_reg.cmd == crf_pkg::CMD_READ) && off_s;
            pix_reg   <= 4'd0;
        end

        if (state_reg == crf_pkg::ST_RWAIT) begin
            pix_reg <= mem_rdata;
        end

        // Load a span, then walk it in raster order
        if (state_reg == crf_pkg::ST_NEXT) begin
            x_reg  <= ld_x0;
            x0_reg <= ld_x0;
            x1_reg <= ld_x1;
            y_reg  <= ld_y0;
            y1_reg <= ld_y1;
        end else if (state_reg == crf_pkg::ST_SPAN) begin
            if (x_end) begin
                x_reg <= x0_reg;
                if (!y_end) begin
                    y_reg <= y_reg + YW'(1);
                end
            end else begin
                x_reg <= x_reg + XW'(1);
            end
        end

        if (done_load) begin
            out_word_reg.pixel_value <= pix_reg;
            out_word_reg.off_canvas  <= off_reg;
        end
    end

endmodule

`default_nettype wire

/* hdl/clipped_raster_fill_engine.sv */
// Top level of the clipped raster fill engine.
//
// Commands arrive as one word on s_valid/s_ready; each gives exactly one completion
// word on m_valid/m_ready (pixel_value and off_canvas, zero except for a read).
// Palette and clip window are written through the APB port at 8-byte strides;
// the user must write them only while no command is in flight (not enforced).
// Work per command, from acceptance to the result register:
//   point        one pixel write,
//   fill         the clipped area, one pixel written per cycle,
//   border       the drawn edges, one span per edge,
//   read         one frame store read, skipped when off the canvas,
//   clear        a sweep over all CANVAS_WIDTH*CANVAS_HEIGHT pixels,
//   empty/other  no pixel writes.
// The single write port of the frame store sets the pace: one pixel per cycle.
// The next command is taken no sooner than the cycle after the result loads.
// After reset a sweep clears all CANVAS_WIDTH*CANVAS_HEIGHT frame store addresses
// (65536 at the default size); s_ready stays low meanwhile, APB writes go on.
// A finished result waits in an output register; the next command is accepted
// while it waits, and the engine holds its own result until that register frees.
`default_nettype none

module clipped_raster_fill_engine #(
    parameter int CANVAS_WIDTH  = 256,
    parameter int CANVAS_HEIGHT = 256,
    parameter int PALETTE_SIZE  = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire crf_pkg::in_word_t  s_word,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output crf_pkg::out_word_t      m_word,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic      [63:0]        prdata,
    output logic                    pready
);

    localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    crf_pkg::cfg_t cfg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [3:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [3:0]    mem_rdata;

    crf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crf_fstore #(
        .DEPTH (DEPTH)
    ) u_fstore (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    crf_engine #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT),
        .PALETTE_SIZE  (PALETTE_SIZE)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
